[rtl/pid_bc_pkg.sv]
// Package for the PID step with back-calculation anti-windup.
// Holds the command codes, register indexes and rounding helpers; no dependencies.
`default_nettype none
package pid_bc_pkg;

	typedef enum logic [1:0] {
		CMD_DERIV = 2'd0,
		CMD_MEAS  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [2:0] REG_WINDUP_GAIN = 3'd3;
	localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;
	localparam logic [2:0] REG_DRIVE_MIN   = 3'd5;
	localparam logic [2:0] REG_DRIVE_MAX   = 3'd6;

	localparam int WIDE_W = 66;
	localparam int PROD_W = 50;

	// Shift right by s, rounding to nearest with ties away from zero.
	function automatic logic signed [WIDE_W-1:0] round_shr(
		input logic signed [WIDE_W-1:0] v,
		input logic [4:0] s
	);
		logic [WIDE_W-1:0] mag;
		logic [WIDE_W-1:0] half;
		half = {{(WIDE_W-1){1'b0}}, 1'b1} << (s - 5'd1);
		mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		mag = (mag + half) >> s;
		return v[WIDE_W-1] ? -$signed(mag) : $signed(mag);
	endfunction

	// Saturate a wide value to the 24-bit term range.
	function automatic logic signed [23:0] sat24(input logic signed [WIDE_W-1:0] v);
		logic signed [23:0] r;
		if (v > $signed(WIDE_W'(24'sh7FFFFF)))
			r = 24'sh7FFFFF;
		else if (v < -$signed(WIDE_W'(25'sh0800000)))
			r = -24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/pid_back_calc_antiwindup.sv]
// Top level of the PID step with back-calculation anti-windup.
// Depends on pid_bc_pkg for command codes, register indexes and rounding.
// Path from the input transfer to out_valid: clear, zero-dt and reserved commands go straight to
// S_OUT; a step with derived rate runs the bit-serial divider (S_DIV), S_RATE, then S_MP to S_FIN;
// a step with measured rate or the first step runs S_MP to S_FIN. One item at a time: the input
// stalls until the result enters the output register, so the next item is accepted in the following
// cycle at the earliest; the sequencer and its shared 33x17 multiplier set the rate. Reset
// (arst_n low, asynchronous) loads register defaults and clears integrator and history.
`default_nettype none
module pid_back_calc_antiwindup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic signed [15:0] error,
	input  wire logic signed [23:0] error_rate,
	input  wire logic [15:0]        dt,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      drive,
	output logic signed [23:0]      p_term,
	output logic signed [23:0]      i_term,
	output logic signed [23:0]      d_term,
	output logic                    skipped,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);
	import pid_bc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_RATE, S_MP, S_MD, S_MI, S_ME, S_CLAMP,
		S_MW1, S_MW2, S_MW3, S_ACC, S_ML, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0]        prop_gain_q, integ_gain_q, deriv_gain_q, windup_gain_q;
	logic [30:0]        integ_limit_q;
	logic signed [15:0] drive_min_q, drive_max_q;

	// controller state
	logic signed [31:0] integ_acc_q;
	logic signed [15:0] prev_error_q;
	logic               first_step_q;
	logic signed [23:0] last_p_q, last_i_q, last_d_q;

	// per-item working registers
	logic signed [15:0] err_q;
	logic [15:0]        dt_q;
	logic signed [23:0] rate_q;
	logic               neg_q;
	logic [15:0]        rem_q;
	logic [31:0]        quo_q;
	logic [4:0]         cnt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [19:0] p_q;
	logic signed [29:0] d_q, unc_q;
	logic signed [15:0] clamped_q;
	logic signed [31:0] eaw_q;
	logic signed [31:0] errdt_q;
	logic signed [48:0] t_q;
	logic signed [PROD_W-1:0] wlow_q;
	logic signed [31:0] acc_q;

	// result and output registers
	logic signed [15:0] res_drive_q;
	logic signed [23:0] res_p_q, res_i_q, res_d_q;
	logic               res_skip_q;
	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic signed [23:0] p_term_q, i_term_q, d_term_q;
	logic               skipped_q;

	// shared multiplier operands
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;

	// combinational helpers
	logic signed [16:0]       diff;
	logic [16:0]              div_try;
	logic signed [WIDE_W-1:0] rnd_in;
	logic signed [WIDE_W-1:0] rnd_out;
	logic [4:0]               rnd_sh;
	logic signed [29:0]       clamp_hi;
	logic signed [WIDE_W-1:0] inc;
	logic signed [55:0]       acc_sum;
	logic signed [55:0]       lim_ext;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign p_term    = p_term_q;
	assign i_term    = i_term_q;
	assign d_term    = d_term_q;
	assign skipped   = skipped_q;

	assign diff    = 17'(error) - 17'(prev_error_q);
	assign div_try = {rem_q, quo_q[31]} - {1'b0, dt_q};

	// Select operands of the shared multiplier for each sequencer step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MP: begin
				mul_a = 33'(err_q);
				mul_b = $signed({1'b0, prop_gain_q});
			end
			S_MD: begin
				mul_a = 33'(rate_q);
				mul_b = $signed({1'b0, deriv_gain_q});
			end
			S_MI: begin
				mul_a = 33'(integ_acc_q);
				mul_b = $signed({1'b0, integ_gain_q});
			end
			S_ME: begin
				mul_a = 33'(err_q);
				mul_b = $signed({1'b0, dt_q});
			end
			S_MW1: begin
				mul_a = 33'(eaw_q);
				mul_b = $signed({1'b0, dt_q});
			end
			S_MW2: begin
				mul_a = $signed({9'b0, prod_q[23:0]});
				mul_b = $signed({1'b0, windup_gain_q});
			end
			S_MW3: begin
				// upper part of windup error times dt keeps its sign
				mul_a = 33'($signed(t_q[48:24]));
				mul_b = $signed({1'b0, windup_gain_q});
			end
			S_ML: begin
				mul_a = 33'(acc_q);
				mul_b = $signed({1'b0, integ_gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round the registered product: Q.12 for p and d, Q.20 for the integral terms.
	always_comb begin
		rnd_in = WIDE_W'(prod_q);
		rnd_sh = (state_q == S_ME || state_q == S_FIN) ? 5'd20 : 5'd12;
		rnd_out = round_shr(rnd_in, rnd_sh);
	end

	assign clamp_hi = (unc_q > 30'(drive_max_q)) ? 30'(drive_max_q) : unc_q;

	// Sum both increments in Q.32, round once to Q12.20, then limit.
	assign inc = (WIDE_W'(errdt_q) <<< 4) + (WIDE_W'(prod_q) <<< 24) + WIDE_W'(wlow_q);
	always_comb begin
		logic signed [WIDE_W-1:0] r;
		r = round_shr(inc, 5'd12);
		acc_sum = 56'(integ_acc_q) + r[55:0];
	end
	assign lim_ext = $signed({25'b0, integ_limit_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			prop_gain_q   <= 16'd256;
			integ_gain_q  <= 16'd0;
			deriv_gain_q  <= 16'd0;
			windup_gain_q <= 16'd0;
			integ_limit_q <= 31'h7FFFFFFF;
			drive_min_q   <= 16'sh8000;
			drive_max_q   <= 16'sd32767;
			integ_acc_q   <= '0;
			prev_error_q  <= '0;
			first_step_q  <= 1'b1;
			last_p_q      <= '0;
			last_i_q      <= '0;
			last_d_q      <= '0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			// register writes; the user must write only while idle, the block itself does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_PROP_GAIN:   prop_gain_q   <= cfg_data[15:0];
					REG_INTEG_GAIN:  integ_gain_q  <= cfg_data[15:0];
					REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data[15:0];
					REG_WINDUP_GAIN: windup_gain_q <= cfg_data[15:0];
					REG_INTEG_LIMIT: integ_limit_q <= cfg_data[30:0];
					REG_DRIVE_MIN:   drive_min_q   <= cfg_data[15:0];
					REG_DRIVE_MAX:   drive_max_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			// drop the output once the receiver takes it; S_OUT refills it itself
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;

			prod_q <= mul_a * mul_b;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						err_q <= error;
						dt_q  <= dt;
						neg_q <= diff[16];
						if (cmd == CMD_CLEAR) begin
							// back to reset state, registers kept
							integ_acc_q  <= '0;
							prev_error_q <= '0;
							first_step_q <= 1'b1;
							last_p_q     <= '0;
							last_i_q     <= '0;
							last_d_q     <= '0;
							res_drive_q  <= '0;
							res_p_q      <= '0;
							res_i_q      <= '0;
							res_d_q      <= '0;
							res_skip_q   <= 1'b0;
							state_q      <= S_OUT;
						end else if (cmd == CMD_RSVD || dt == 16'd0) begin
							// ignored step: report stored terms
							res_drive_q <= '0;
							res_p_q     <= last_p_q;
							res_i_q     <= last_i_q;
							res_d_q     <= last_d_q;
							res_skip_q  <= 1'b1;
							state_q     <= S_OUT;
						end else if (cmd == CMD_MEAS) begin
							rate_q  <= error_rate;
							state_q <= S_MP;
						end else if (first_step_q) begin
							rate_q  <= '0;
							state_q <= S_MP;
						end else begin
							rem_q   <= '0;
							quo_q   <= {(diff[16] ? 16'(-diff) : diff[15:0]), 16'b0};
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// one quotient bit a cycle, restoring
					if (!div_try[16]) begin
						rem_q <= div_try[15:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[14:0], quo_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= S_RATE;
				end
				S_RATE: begin
					if (neg_q)
						rate_q <= (quo_q > 32'd8388608) ? 24'sh800000 : 24'(-$signed(quo_q));
					else
						rate_q <= (quo_q > 32'd8388607) ? 24'sd8388607 : quo_q[23:0];
					state_q <= S_MP;
				end
				S_MP: state_q <= S_MD;
				S_MD: begin
					p_q     <= rnd_out[19:0];
					state_q <= S_MI;
				end
				S_MI: begin
					d_q     <= rnd_out[29:0];
					state_q <= S_ME;
				end
				S_ME: begin
					unc_q   <= 30'(p_q) + d_q + rnd_out[29:0];
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					errdt_q   <= prod_q[31:0];
					clamped_q <= (clamp_hi < 30'(drive_min_q)) ? drive_min_q : clamp_hi[15:0];
					eaw_q     <= 32'((clamp_hi < 30'(drive_min_q) ? 30'(drive_min_q) : clamp_hi)
						- unc_q);
					state_q   <= S_MW1;
				end
				S_MW1: state_q <= S_MW2;
				S_MW2: begin
					t_q     <= prod_q[48:0];
					state_q <= S_MW3;
				end
				S_MW3: begin
					wlow_q  <= prod_q;
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (acc_sum > lim_ext)
						acc_q <= 32'(lim_ext);
					else if (acc_sum < -lim_ext)
						acc_q <= 32'(-lim_ext);
					else
						acc_q <= acc_sum[31:0];
					state_q <= S_ML;
				end
				S_ML: begin
					integ_acc_q  <= acc_q;
					prev_error_q <= err_q;
					first_step_q <= 1'b0;
					last_p_q     <= sat24(WIDE_W'(p_q));
					last_d_q     <= sat24(WIDE_W'(d_q));
					state_q      <= S_FIN;
				end
				S_FIN: begin
					last_i_q    <= sat24(rnd_out);
					res_drive_q <= clamped_q;
					res_p_q     <= last_p_q;
					res_i_q     <= sat24(rnd_out);
					res_d_q     <= last_d_q;
					res_skip_q  <= 1'b0;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					// transfer into the output register once it is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						drive_q     <= res_drive_q;
						p_term_q    <= res_p_q;
						i_term_q    <= res_i_q;
						d_term_q    <= res_d_q;
						skipped_q   <= res_skip_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
